>>> sv/msp_rx_pkg.sv
`timescale 1ns / 1ps

package msp_rx_pkg;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_M    = 3'd1;
  localparam logic [2:0] PH_GT   = 3'd2;
  localparam logic [2:0] PH_SIZE = 3'd3;
  localparam logic [2:0] PH_CODE = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] SZ_EXACT = 2'd0;
  localparam logic [1:0] SZ_SHORT = 2'd1;
  localparam logic [1:0] SZ_LONG  = 2'd2;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] running_xor;
    logic [7:0] byte_count;
    logic [7:0] held_size;
    logic [7:0] held_code;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] frame_code;
    logic [7:0] frame_size;
    logic       checksum_ok;
    logic [1:0] size_status;
    logic       last;
  } result_t;

endpackage

>>> sv/msp_rx_in_if.sv
`timescale 1ns / 1ps

interface msp_rx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/msp_rx_out_if.sv
`timescale 1ns / 1ps

interface msp_rx_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [7:0] frame_code;
  logic [7:0] frame_size;
  logic       checksum_ok;
  logic [1:0] size_status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output frame_code, output frame_size, output checksum_ok,
                  output size_status, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input data_index,
                input frame_code, input frame_size, input checksum_ok,
                input size_status, input last, output ready);
endinterface

>>> sv/msp_rx_step.sv
`timescale 1ns / 1ps

module msp_rx_step (
  input  msp_rx_pkg::state_t  st,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          buf_len,
  output msp_rx_pkg::state_t  st_nxt,
  output logic                emit,
  output msp_rx_pkg::result_t res
);
  import msp_rx_pkg::*;

  logic [2:0] restart_ph;
  logic [7:0] count_inc;

  assign restart_ph = (rx_byte == CH_DOLLAR) ? PH_M : PH_HUNT;
  assign count_inc  = st.byte_count + 8'd1;

  always_comb begin
    st_nxt          = st;
    emit            = 1'b0;
    res.kind        = KIND_DATA;
    res.data_byte   = 8'd0;
    res.data_index  = 8'd0;
    res.frame_code  = st.held_code;
    res.frame_size  = st.held_size;
    res.checksum_ok = 1'b0;
    res.size_status = SZ_EXACT;
    res.last        = 1'b0;

    unique case (st.phase)
      PH_M: begin
        st_nxt.phase = (rx_byte == CH_M) ? PH_GT : restart_ph;
      end
      PH_GT: begin
        st_nxt.phase = (rx_byte == CH_GT) ? PH_SIZE : restart_ph;
      end
      PH_SIZE: begin
        st_nxt.held_size   = rx_byte;
        st_nxt.running_xor = rx_byte;
        st_nxt.byte_count  = 8'd0;
        st_nxt.phase       = PH_CODE;
      end
      PH_CODE: begin
        st_nxt.held_code   = rx_byte;
        st_nxt.running_xor = st.running_xor ^ rx_byte;
        st_nxt.phase       = (st.held_size == 8'd0) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        st_nxt.running_xor = st.running_xor ^ rx_byte;
        st_nxt.byte_count  = count_inc;
        // bytes past the caller's buffer still feed the checksum
        if (st.byte_count < buf_len) begin
          emit           = 1'b1;
          res.data_byte  = rx_byte;
          res.data_index = st.byte_count;
        end
        if (count_inc >= st.held_size) begin
          st_nxt.phase = PH_CSUM;
        end
      end
      PH_CSUM: begin
        emit            = 1'b1;
        res.kind        = KIND_END;
        res.last        = 1'b1;
        res.checksum_ok = (st.running_xor == rx_byte);
        if (st.held_size == buf_len) begin
          res.size_status = SZ_EXACT;
        end else if (st.held_size < buf_len) begin
          res.size_status = SZ_SHORT;
        end else begin
          res.size_status = SZ_LONG;
        end
        st_nxt.phase = PH_HUNT;
      end
      default: begin
        st_nxt.phase = restart_ph;
      end
    endcase
  end

endmodule

>>> sv/msp_frame_receiver_top.sv
`timescale 1ns / 1ps
// Response-frame receiver: one received byte per item, at most one result per item.
// Latency: a result is valid on the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register lets the next byte in
// while a result waits, as long as that result is taken in the same cycle.
// Reset (rst_n low, synchronous): parser back to preamble hunt, running XOR,
// counters and held size/code cleared, buffer size register = 0, no result pending.

module msp_frame_receiver_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  msp_rx_in_if.sink          in_chan,
  msp_rx_out_if.source       out_chan
);
  import msp_rx_pkg::*;

  logic [7:0] exp_size_r;
  state_t     st_r;
  state_t     st_nxt;
  logic       emit;
  result_t    res;
  result_t    res_r;
  logic       out_valid_r;
  logic       in_fire;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  msp_rx_step u_step (
    .st            (st_r),
    .rx_byte       (in_chan.rx_byte),
    .buf_len       (exp_size_r),
    .st_nxt        (st_nxt),
    .emit          (emit),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_size_r <= 8'd0;
    end else if (cfg_we) begin
      exp_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      st_r        <= st_nxt;
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = res_r.kind;
  assign out_chan.data_byte   = res_r.data_byte;
  assign out_chan.data_index  = res_r.data_index;
  assign out_chan.frame_code  = res_r.frame_code;
  assign out_chan.frame_size  = res_r.frame_size;
  assign out_chan.checksum_ok = res_r.checksum_ok;
  assign out_chan.size_status = res_r.size_status;
  assign out_chan.last        = res_r.last;

  a_csum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st_r.phase == PH_CSUM |=> st_r.phase == PH_HUNT && out_valid_r && res_r.last)
    else $error("checksum byte did not close the frame");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DATA |-> st_r.byte_count < st_r.held_size)
    else $error("payload count ran past frame size");

  a_data_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == KIND_DATA |-> res_r.data_index < exp_size_r)
    else $error("data item outside expected size");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r && !out_chan.ready)
    else $error("input stalled without a pending result");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import msp_rx_pkg::*;

  localparam int QUIET_LIMIT = 500;
  localparam int ITEM_BUDGET = 1950;
  localparam int SETTLE_CYCLES = 3;

  typedef logic [7:0] byte_q_t [$];

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  msp_rx_in_if  rx_if ();
  msp_rx_out_if res_if ();

  msp_frame_receiver_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (rx_if),
    .out_chan (res_if)
  );

  // Parser copy, advanced on every accepted byte.
  logic [2:0] prs_phase = PH_HUNT;
  logic [7:0] prs_xor   = '0;
  logic [7:0] prs_count = '0;
  logic [7:0] prs_size  = '0;
  logic [7:0] prs_code  = '0;
  logic [7:0] buf_size  = '0;

  result_t frame_results_due [$];
  int      errors;
  bit      idling;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [2:0] hunt_from(input logic [7:0] b);
    return (b == CH_DOLLAR) ? PH_M : PH_HUNT;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.frame_code = prs_code;
    r.frame_size = prs_size;
    case (prs_phase)
      PH_M: prs_phase = (b == CH_M) ? PH_GT : hunt_from(b);
      PH_GT: prs_phase = (b == CH_GT) ? PH_SIZE : hunt_from(b);
      PH_SIZE: begin
        prs_size  = b;
        prs_xor   = b;
        prs_count = '0;
        prs_phase = PH_CODE;
      end
      PH_CODE: begin
        prs_code  = b;
        prs_xor   = prs_xor ^ b;
        prs_phase = (prs_size == 0) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        prs_xor = prs_xor ^ b;
        if (prs_count < buf_size) begin
          r.kind       = KIND_DATA;
          r.data_byte  = b;
          r.data_index = prs_count;
          frame_results_due.push_back(r);
        end
        prs_count = prs_count + 8'd1;
        if (prs_count >= prs_size) prs_phase = PH_CSUM;
      end
      PH_CSUM: begin
        r.kind        = KIND_END;
        r.checksum_ok = (prs_xor == b);
        r.size_status = (prs_size == buf_size) ? SZ_EXACT :
                        (prs_size < buf_size) ? SZ_SHORT : SZ_LONG;
        r.last        = 1'b1;
        frame_results_due.push_back(r);
        prs_phase = PH_HUNT;
      end
      default: prs_phase = hunt_from(b);
    endcase
  endfunction

  // Returns at the edge where the byte is taken; valid is left high.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    parse_rx_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] size, input logic [7:0] code,
                            input byte_q_t payload, input bit bad_csum,
                            input bit cut_short);
    logic [7:0] csum;
    int         n;
    csum = size ^ code;
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(CH_GT);
    send_byte(size);
    send_byte(code);
    n = cut_short ? payload.size() / 2 : payload.size();
    for (int i = 0; i < n; i++) begin
      csum = csum ^ payload[i];
      send_byte(payload[i]);
    end
    if (!cut_short) begin
      if (bad_csum) csum = csum ^ 8'($urandom_range(1, 255));
      send_byte(csum);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic settle_parser();
    rx_if.valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buf_size(input logic [7:0] v);
    settle_parser();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    buf_size = v;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (frame_results_due.size() == 0) begin
      errors++;
      $display("%0t: result expected none, got kind %0d byte %02h code %02h",
               $time, res_if.kind, res_if.data_byte, res_if.frame_code);
    end else begin
      want = frame_results_due.pop_front();
      check_field("kind", 8'(want.kind), 8'(res_if.kind));
      check_field("data_byte", want.data_byte, res_if.data_byte);
      check_field("data_index", want.data_index, res_if.data_index);
      check_field("frame_code", want.frame_code, res_if.frame_code);
      check_field("frame_size", want.frame_size, res_if.frame_size);
      check_field("checksum_ok", 8'(want.checksum_ok), 8'(res_if.checksum_ok));
      check_field("size_status", 8'(want.size_status), 8'(res_if.size_status));
      check_field("last", 8'(want.last), 8'(res_if.last));
    end
  endtask

  // Result side: check every taken item, then, while idling, stall a random number of cycles.
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        check_result();
        stall = idling ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // '$' mid-preamble restarts the match; empty payload; register at reset value.
  task automatic test_preamble_restart();
    byte_q_t none;
    none = {};
    idling = 1'b1;
    send_byte(CH_DOLLAR);
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_frame(8'h00, 8'hFF, none, 1'b0, 1'b0);
  endtask

  task automatic test_short_frame();
    write_buf_size(8'hFF);
    send_frame(8'h01, 8'h00, {8'hFF}, 1'b1, 1'b0);
  endtask

  task automatic test_long_frame();
    write_buf_size(8'h01);
    send_frame(8'h02, 8'h80, {8'h00, 8'h80}, 1'b0, 1'b0);
  endtask

  task automatic test_random_frames();
    int          sent;
    int          near;
    int unsigned roll;
    logic [7:0]  size;
    byte_q_t     payload;
    sent = 0;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_buf_size(8'hFF);
        1: write_buf_size(8'h00);
        2: write_buf_size(8'($urandom_range(0, 255)));
        default: write_buf_size(8'($urandom_range(0, 12)));
      endcase
      idling = (p != 3);
      while (sent < ITEM_BUDGET * (p + 1) / 8) begin
        if ($urandom_range(0, 9) == 0) idling = !idling;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (roll < 13) begin
          send_byte(CH_DOLLAR);
          if ($urandom_range(0, 1)) send_byte(CH_M);
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2) begin
            size = 8'($urandom_range(13, 255));
          end else if (roll < 25 && buf_size <= 16) begin
            near = int'(buf_size) + int'($urandom_range(0, 2)) - 1;
            size = (near < 0) ? 8'd0 : 8'(near);
          end else begin
            size = 8'($urandom_range(0, 12));
          end
          payload = {};
          for (int i = 0; i < size; i++) payload.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 99) < 4 && size > 1) begin
            send_frame(size, 8'($urandom_range(0, 255)), payload, 1'b0, 1'b1);
            sent += 5 + size / 2;
          end else begin
            send_frame(size, 8'($urandom_range(0, 255)), payload,
                       $urandom_range(0, 99) < 15, 1'b0);
            sent += 6 + size;
          end
          if ($urandom_range(0, 99) < 3) settle_parser();
        end
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    errors        = 0;
    idling        = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preamble_restart();
    test_short_frame();
    test_long_frame();
    test_random_frames();
    settle_parser();
    repeat (4) @(posedge clk);
    errors += frame_results_due.size();
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
sv/msp_rx_pkg.sv
sv/msp_rx_in_if.sv
sv/msp_rx_out_if.sv
sv/msp_rx_step.sv
sv/msp_frame_receiver_top.sv
sim/tb.sv
